// File: rtl/core/mbrtu_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus coil-write master.
`default_nettype none
package mbrtu_pkg;

	localparam int REPLY_BUFFER_BYTES = 256;
	localparam int CNT_W = $clog2(REPLY_BUFFER_BYTES + 1);
	localparam int LEN_W = 9;
	localparam int REQ_LEN = 8;
	localparam int TMO_W = 16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] FUNC_WRITE_COIL = 8'h05;
	localparam logic [7:0] FUNC_EXCEPTION = 8'h85;
	localparam logic [7:0] COIL_ON_BYTE = 8'hFF;
	localparam logic [7:0] COIL_OFF_BYTE = 8'h00;

	// Reply byte positions that carry the function and exception code,
	// without and with a leading echo of the request.
	localparam int POS_FUNC = 1;
	localparam int POS_CODE = 2;
	localparam int POS_FUNC_ECHO = 9;
	localparam int POS_CODE_ECHO = 10;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_TICK = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_TIMEOUT = 3'd1,
		ST_SHORT = 3'd2,
		ST_CRC_FAIL = 3'd3,
		ST_EXCEPTION = 3'd4
	} status_t;

	typedef enum logic {
		REG_FIRST_TIMEOUT = 1'b0,
		REG_INTER_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] slave_id;
		logic [15:0] coil_address;
		logic coil_on;
		logic [7:0] rx_data;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [7:0] tx_data;
		logic last;
		logic [2:0] status;
		logic [7:0] exception_code;
		logic [LEN_W-1:0] reply_length;
	} result_t;

	typedef logic [REQ_LEN-1:0][7:0] req_bytes_t;

	// Result request from the transaction logic to the output sequencer.
	typedef struct packed {
		logic load_req;
		logic load_stat;
		logic [7:0] slave_id;
		logic [15:0] coil_address;
		logic coil_on;
		logic [2:0] status;
		logic [7:0] exception_code;
		logic [LEN_W-1:0] reply_length;
	} push_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/modbus_rtu_write_coil_master_unit.sv
// Top level of the Modbus RTU function 05 master: register port, input register and submodules.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_ready     item   (mbrtu_pkg::item_t)
//   result    out        result_valid / result_ready result (mbrtu_pkg::result_t)
//   config    in         psel / penable / pready     paddr, pwdata, pwrite, prdata
//
// Each item is registered, then handled by the transaction logic; an item
// that causes no result (byte, tick without timeout) leaves the input register every cycle.
// A start gives eight request bytes and a timeout one status transaction; those wait only
// until the output sequencer has sent the final part of the previous result, sent one per
// cycle while result_ready is high. The request CRC is built in the sequencer after a start.
// Reset idles the block and loads timeouts of 500 and 10 ticks; no clearing pass is needed.
`default_nettype none
module modbus_rtu_write_coil_master_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire mbrtu_pkg::item_t item,
	output logic result_valid,
	input wire logic result_ready,
	output mbrtu_pkg::result_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [mbrtu_pkg::TMO_W-1:0] first_timeout_q;
	logic [mbrtu_pkg::TMO_W-1:0] inter_timeout_q;
	logic valid_s1;
	mbrtu_pkg::item_t item_s1;
	logic consume;
	logic emit_free;
	mbrtu_pkg::push_t push;
	mbrtu_pkg::req_bytes_t req_bytes;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_timeout_q <= 16'd500;
			inter_timeout_q <= 16'd10;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				mbrtu_pkg::REG_FIRST_TIMEOUT: first_timeout_q <= pwdata[15:0];
				mbrtu_pkg::REG_INTER_TIMEOUT: inter_timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mbrtu_pkg::REG_FIRST_TIMEOUT: prdata = {16'h0000, first_timeout_q};
			mbrtu_pkg::REG_INTER_TIMEOUT: prdata = {16'h0000, inter_timeout_q};
			default: prdata = '0;
		endcase
	end

	assign item_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	mbrtu_proc u_proc (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid_s1),
		.item(item_s1),
		.emit_free(emit_free),
		.req_bytes(req_bytes),
		.first_timeout(first_timeout_q),
		.inter_timeout(inter_timeout_q),
		.consume(consume),
		.push(push)
	);

	mbrtu_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.free(emit_free),
		.req_bytes(req_bytes),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule
`default_nettype wire

// File: rtl/core/mbrtu_emit.sv
// Output sequencer: holds the request bytes, builds their CRC and sends results one at a time.
`default_nettype none
module mbrtu_emit (
	input wire logic clk,
	input wire logic arst_n,
	input wire mbrtu_pkg::push_t push,
	output logic free,
	output mbrtu_pkg::req_bytes_t req_bytes,
	output logic result_valid,
	input wire logic result_ready,
	output mbrtu_pkg::result_t result
);

	logic [5:0][7:0] req_q;
	logic [15:0] crc_q;
	logic [2:0] crc_pos_q;
	logic valid_q;
	logic stat_q;
	logic [2:0] idx_q;
	logic [2:0] status_q;
	logic [7:0] exc_q;
	logic [mbrtu_pkg::LEN_W-1:0] len_q;
	logic final_item;

	assign final_item = stat_q || (idx_q == 3'(mbrtu_pkg::REQ_LEN - 1));
	assign free = !valid_q || (result_ready && final_item);

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			req_bytes[i] = req_q[i];
		end
		req_bytes[6] = crc_q[7:0];
		req_bytes[7] = crc_q[15:8];
	end

	always_comb begin
		result.kind = stat_q;
		result.tx_data = stat_q ? 8'h00 : req_bytes[idx_q];
		result.last = !stat_q && final_item;
		result.status = stat_q ? status_q : 3'(mbrtu_pkg::ST_OK);
		result.exception_code = stat_q ? exc_q : 8'h00;
		result.reply_length = stat_q ? len_q : '0;
	end
	assign result_valid = valid_q;

	// The CRC runs one byte per cycle after a load; byte six is needed only after six
	// earlier bytes have gone out on the bus or passed the echo check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			crc_q <= '0;
			crc_pos_q <= 3'd6;
		end else if (push.load_req) begin
			req_q[0] <= push.slave_id;
			req_q[1] <= mbrtu_pkg::FUNC_WRITE_COIL;
			req_q[2] <= push.coil_address[15:8];
			req_q[3] <= push.coil_address[7:0];
			req_q[4] <= push.coil_on ? mbrtu_pkg::COIL_ON_BYTE : mbrtu_pkg::COIL_OFF_BYTE;
			req_q[5] <= 8'h00;
			crc_q <= mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, push.slave_id);
			crc_pos_q <= 3'd1;
		end else if (crc_pos_q != 3'd6) begin
			crc_q <= mbrtu_pkg::crc_byte(crc_q, req_bytes[crc_pos_q]);
			crc_pos_q <= crc_pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			stat_q <= 1'b0;
			idx_q <= '0;
		end else if (push.load_req) begin
			valid_q <= 1'b1;
			stat_q <= 1'b0;
			idx_q <= '0;
		end else if (push.load_stat) begin
			valid_q <= 1'b1;
			stat_q <= 1'b1;
			idx_q <= '0;
		end else if (valid_q && result_ready) begin
			if (final_item) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.load_stat) begin
			status_q <= push.status;
			exc_q <= push.exception_code;
			len_q <= push.reply_length;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/mbrtu_proc.sv
// Transaction logic: reply collection, running CRCs, echo detection and timeout status.
`default_nettype none
module mbrtu_proc (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	input wire mbrtu_pkg::item_t item,
	input wire logic emit_free,
	input wire mbrtu_pkg::req_bytes_t req_bytes,
	input wire logic [mbrtu_pkg::TMO_W-1:0] first_timeout,
	input wire logic [mbrtu_pkg::TMO_W-1:0] inter_timeout,
	output logic consume,
	output mbrtu_pkg::push_t push
);

	localparam int CW = mbrtu_pkg::CNT_W;

	logic busy_q;
	logic [CW-1:0] count_q;
	logic receiving_q;
	logic [mbrtu_pkg::TMO_W-1:0] silence_q;
	logic echo_q;
	logic [15:0] crc_whole_q;
	logic [15:0] crc_after_q;
	logic [3:0][7:0] fc_q;

	logic do_start;
	logic do_byte;
	logic do_tick;
	logic timed_out;
	logic need_result;
	logic echo;
	logic [CW-1:0] len;
	logic [15:0] crc_sel;
	logic [7:0] func_sel;
	logic [7:0] code_sel;
	logic [2:0] status;
	logic [7:0] exc;

	assign do_start = (item.cmd == mbrtu_pkg::CMD_START) && !busy_q;
	assign do_byte = (item.cmd == mbrtu_pkg::CMD_BYTE) && busy_q
		&& (count_q < CW'(mbrtu_pkg::REPLY_BUFFER_BYTES));
	assign do_tick = (item.cmd == mbrtu_pkg::CMD_TICK) && busy_q;
	assign timed_out = silence_q >= (receiving_q ? inter_timeout : first_timeout);

	assign need_result = do_start || (do_tick && timed_out);
	assign consume = valid && (!need_result || emit_free);

	always_comb begin
		echo = echo_q && (count_q >= CW'(mbrtu_pkg::REQ_LEN));
		len = echo ? count_q - CW'(mbrtu_pkg::REQ_LEN) : count_q;
		crc_sel = echo ? crc_after_q : crc_whole_q;
		func_sel = echo ? fc_q[2] : fc_q[0];
		code_sel = echo ? fc_q[3] : fc_q[1];
		exc = 8'h00;
		if (len == '0) begin
			status = 3'(mbrtu_pkg::ST_TIMEOUT);
		end else if (len < CW'(mbrtu_pkg::REQ_LEN)) begin
			status = 3'(mbrtu_pkg::ST_SHORT);
		end else if (crc_sel != 16'h0000) begin
			status = 3'(mbrtu_pkg::ST_CRC_FAIL);
		end else if (func_sel == mbrtu_pkg::FUNC_EXCEPTION) begin
			status = 3'(mbrtu_pkg::ST_EXCEPTION);
			exc = code_sel;
		end else begin
			status = 3'(mbrtu_pkg::ST_OK);
		end
	end

	always_comb begin
		push.load_req = consume && do_start;
		push.load_stat = consume && do_tick && timed_out;
		push.slave_id = item.slave_id;
		push.coil_address = item.coil_address;
		push.coil_on = item.coil_on;
		push.status = status;
		push.exception_code = exc;
		push.reply_length = mbrtu_pkg::LEN_W'(len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			receiving_q <= 1'b0;
			silence_q <= '0;
			echo_q <= 1'b1;
			crc_whole_q <= mbrtu_pkg::CRC_INIT;
			crc_after_q <= mbrtu_pkg::CRC_INIT;
			fc_q <= '0;
		end else if (consume) begin
			if (do_start) begin
				busy_q <= 1'b1;
				count_q <= '0;
				receiving_q <= 1'b0;
				silence_q <= '0;
				echo_q <= 1'b1;
				crc_whole_q <= mbrtu_pkg::CRC_INIT;
				crc_after_q <= mbrtu_pkg::CRC_INIT;
				fc_q <= '0;
			end else if (do_byte) begin
				if ((count_q < CW'(mbrtu_pkg::REQ_LEN)) && (item.rx_data != req_bytes[count_q[2:0]])) begin
					echo_q <= 1'b0;
				end
				crc_whole_q <= mbrtu_pkg::crc_byte(crc_whole_q, item.rx_data);
				if (count_q >= CW'(mbrtu_pkg::REQ_LEN)) begin
					crc_after_q <= mbrtu_pkg::crc_byte(crc_after_q, item.rx_data);
				end
				if (count_q == CW'(mbrtu_pkg::POS_FUNC)) begin
					fc_q[0] <= item.rx_data;
				end
				if (count_q == CW'(mbrtu_pkg::POS_CODE)) begin
					fc_q[1] <= item.rx_data;
				end
				if (count_q == CW'(mbrtu_pkg::POS_FUNC_ECHO)) begin
					fc_q[2] <= item.rx_data;
				end
				if (count_q == CW'(mbrtu_pkg::POS_CODE_ECHO)) begin
					fc_q[3] <= item.rx_data;
				end
				count_q <= count_q + CW'(1);
				receiving_q <= 1'b1;
				silence_q <= '0;
			end else if (do_tick) begin
				if (timed_out) begin
					busy_q <= 1'b0;
				end else begin
					silence_q <= silence_q + mbrtu_pkg::TMO_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire
